// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the dual Monod growth-rate RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DMGR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DMGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dmgr_pkg.sv -----
// Types and constants for the dual Monod growth-rate core.
// No dependencies; imported by every module of the block.
package dmgr_pkg;

	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int KMAG_W      = 35;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [2:0] {
		REG_GROWTH = 3'd0,
		REG_YIELD  = 3'd1,
		REG_MAINT  = 3'd2,
		REG_DECAY  = 3'd3,
		REG_K1     = 3'd4,
		REG_K2     = 3'd5
	} reg_idx_t;

	localparam logic [31:0] YIELD_RST  = 32'd65536;
	localparam logic [31:0] STOICH_Q16 = 32'd224133;  // 3.42 in Q16.16
	localparam longint unsigned KMAG_RST_V =
		((64'(STOICH_Q16) - 64'(YIELD_RST)) << 16) / 64'(YIELD_RST);
	localparam logic [KMAG_W-1:0] KMAG_RST = KMAG_W'(KMAG_RST_V);

	localparam logic [39:0] POS_MAX = {1'b0, {39{1'b1}}};
	localparam logic [39:0] NEG_MIN = {1'b1, 39'd0};

	typedef struct packed {
		logic [31:0]       growth;
		logic [31:0]       yield;
		logic [31:0]       maint;
		logic [31:0]       decay;
		logic [31:0]       k1;
		logic [31:0]       k2;
		logic [KMAG_W-1:0] kmag;   // |(3.42 - yield) / yield|, Q19.16
		logic              kneg;
	} cfg_t;

	typedef struct packed {
		logic [31:0] s1;
		logic [31:0] s2;
		logic [31:0] dens;
		logic        in_dom;
		logic        last;
		logic [32:0] den1;
		logic [32:0] den2;
	} item_t;

	typedef struct packed {
		logic empty;
		logic afull;
		logic full;
	} q_stat_t;

endpackage

// ----- hw/rtl/dual_monod_growth_rate_core.sv -----
// Channel   Handshake                 Payload
// config    psel/penable/pwrite/pready paddr, pwdata, prdata (6 regs, byte addr 4*i)
// cell in   start, busy               ammonium_conc, oxygen_conc, biomass_density,
//                                     in_domain, last_cell
// result    done (one-cycle strobe)   ammonium_rate, oxygen_rate, nitrite_rate,
//                                     specific_growth, last_out
//
// One cell per cycle sustained while busy is low; each cell runs through the 17-step
// fraction dividers and the 40-step ammonium divider, one bit per stage, before its
// result strobes. A nonzero biomass_yield write holds busy high while the
// stoichiometry factor is divided out one bit a cycle. Reset is asynchronous, active
// low; registers take their documented values. The result side has no backpressure.
// Top level; depends on dmgr_pkg, dmgr_cfg, dmgr_front, dmgr_queue, dmgr_back.
`include "assert_macros.svh"

module dual_monod_growth_rate_core #(
	parameter int QUEUE_DEPTH = dmgr_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dmgr_pkg::ADDR_W-1:0] paddr,
	input  logic [dmgr_pkg::DATA_W-1:0] pwdata,
	output logic [dmgr_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  logic [31:0]                 ammonium_conc,
	input  logic [31:0]                 oxygen_conc,
	input  logic [31:0]                 biomass_density,
	input  logic                        in_domain,
	input  logic                        last_cell,
	output logic                        done,
	output logic signed [39:0]          ammonium_rate,
	output logic signed [39:0]          oxygen_rate,
	output logic signed [39:0]          nitrite_rate,
	output logic signed [39:0]          specific_growth,
	output logic                        last_out
);
	import dmgr_pkg::*;

	cfg_t    cfg;
	logic    kbusy;
	q_stat_t q_stat;
	logic    q_push, q_pop;
	item_t   q_in, q_head;

	dmgr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.kbusy   (kbusy)
	);

	dmgr_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.ammonium_conc   (ammonium_conc),
		.oxygen_conc     (oxygen_conc),
		.biomass_density (biomass_density),
		.in_domain       (in_domain),
		.last_cell       (last_cell),
		.cfg             (cfg),
		.kbusy           (kbusy),
		.q_stat          (q_stat),
		.busy            (busy),
		.push            (q_push),
		.push_item       (q_in)
	);

	dmgr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	dmgr_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.q_stat          (q_stat),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.done            (done),
		.ammonium_rate   (ammonium_rate),
		.oxygen_rate     (oxygen_rate),
		.nitrite_rate    (nitrite_rate),
		.specific_growth (specific_growth),
		.last_out        (last_out)
	);

	`DMGR_ASSERT_IMPLY(a_queue_no_overflow, clk, arst_n, q_push, !q_stat.full, "queue overflow")
	`DMGR_ASSERT_NEXT(a_yield_starts_div, clk, arst_n, psel && penable && pwrite && pready && paddr[4:2] == REG_YIELD && pwdata != '0, kbusy, "yield write did not start divider")
	`DMGR_ASSERT_IMPLY(a_amm_nit_pair, clk, arst_n, done, (ammonium_rate == '0) == (nitrite_rate == '0) && !nitrite_rate[39] && (ammonium_rate[39] || ammonium_rate == '0), "ammonium and nitrite rates disagree")

endmodule

// ----- hw/rtl/dmgr_cfg.sv -----
// Register file on the APB-style port, plus the iterative divider that
// forms the oxygen stoichiometry factor after each nonzero yield write. Uses dmgr_pkg.
module dmgr_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [dmgr_pkg::ADDR_W-1:0] paddr,
	input  logic [dmgr_pkg::DATA_W-1:0] pwdata,
	output logic [dmgr_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output dmgr_pkg::cfg_t             cfg,
	output logic                       kbusy
);
	import dmgr_pkg::*;

	localparam int KSTEPS = 48;

	logic [31:0] growth_q, yield_q, maint_q, decay_q, k1_q, k2_q;
	logic [KMAG_W-1:0] kmag_q;
	logic kneg_q, kbusy_q;
	logic [5:0] kcnt_q;
	logic [31:0] kr_q;
	logic [47:0] kq_q, kn_q;
	logic wr;
	reg_idx_t idx;
	logic [32:0] krs;
	logic kge;
	logic [31:0] kr_nxt, kdiff;
	logic [47:0] kq_nxt;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && pready;
	assign idx = reg_idx_t'(paddr[4:2]);

	always_comb begin
		case (idx)
			REG_GROWTH: prdata = growth_q;
			REG_YIELD:  prdata = yield_q;
			REG_MAINT:  prdata = maint_q;
			REG_DECAY:  prdata = decay_q;
			REG_K1:     prdata = k1_q;
			REG_K2:     prdata = k2_q;
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			growth_q <= '0;
			yield_q  <= YIELD_RST;
			maint_q  <= '0;
			decay_q  <= '0;
			k1_q     <= '0;
			k2_q     <= '0;
		end else if (wr) begin
			case (idx)
				REG_GROWTH: growth_q <= pwdata;
				REG_YIELD:  yield_q  <= pwdata;
				REG_MAINT:  maint_q  <= pwdata;
				REG_DECAY:  decay_q  <= pwdata;
				REG_K1:     k1_q     <= pwdata;
				REG_K2:     k2_q     <= pwdata;
				default:    ;
			endcase
		end
	end

	// restoring division, one quotient bit per cycle
	assign kdiff  = (pwdata > STOICH_Q16) ? pwdata - STOICH_Q16 : STOICH_Q16 - pwdata;
	assign krs    = {kr_q, kn_q[47]};
	assign kge    = krs >= {1'b0, yield_q};
	assign kr_nxt = kge ? 32'(krs - {1'b0, yield_q}) : krs[31:0];
	assign kq_nxt = {kq_q[46:0], kge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kbusy_q <= 1'b0;
			kcnt_q  <= '0;
			kmag_q  <= KMAG_RST;
			kneg_q  <= 1'b0;
		end else if (wr && idx == REG_YIELD) begin
			kbusy_q <= pwdata != '0;
			kcnt_q  <= 6'(KSTEPS - 1);
			kneg_q  <= pwdata > STOICH_Q16;
			if (pwdata == '0) begin
				kmag_q <= '0;
			end
		end else if (kbusy_q) begin
			kcnt_q <= kcnt_q - 6'd1;
			if (kcnt_q == '0) begin
				kbusy_q <= 1'b0;
				kmag_q  <= kq_nxt[KMAG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr && idx == REG_YIELD) begin
			kr_q <= '0;
			kq_q <= '0;
			kn_q <= {kdiff, 16'd0};
		end else if (kbusy_q) begin
			kr_q <= kr_nxt;
			kq_q <= kq_nxt;
			kn_q <= {kn_q[46:0], 1'b0};
		end
	end

	assign kbusy = kbusy_q;

	always_comb begin
		cfg.growth = growth_q;
		cfg.yield  = yield_q;
		cfg.maint  = maint_q;
		cfg.decay  = decay_q;
		cfg.k1     = k1_q;
		cfg.k2     = k2_q;
		cfg.kmag   = kmag_q;
		cfg.kneg   = kneg_q;
	end

endmodule

// ----- hw/rtl/dmgr_queue.sv -----
// Short register FIFO between the front end and the compute pipeline.
// Uses dmgr_pkg for the entry and status types.
module dmgr_queue #(
	parameter int DEPTH = dmgr_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dmgr_pkg::item_t    push_item,
	input  logic               pop,
	output dmgr_pkg::item_t    head,
	output dmgr_pkg::q_stat_t  stat
);
	import dmgr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	assign head       = mem_q[rd_q];
	assign stat.empty = count_q == '0;
	assign stat.afull = count_q >= CW'(DEPTH - 1);
	assign stat.full  = count_q == CW'(DEPTH);

endmodule

// ----- hw/rtl/dmgr_front.sv -----
// Front end: takes a cell on start while not busy, forms the Monod denominators and
// pushes the classified item into the queue. Uses dmgr_pkg.
module dmgr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        ammonium_conc,
	input  logic [31:0]        oxygen_conc,
	input  logic [31:0]        biomass_density,
	input  logic               in_domain,
	input  logic               last_cell,
	input  dmgr_pkg::cfg_t     cfg,
	input  logic               kbusy,
	input  dmgr_pkg::q_stat_t  q_stat,
	output logic               busy,
	output logic               push,
	output dmgr_pkg::item_t    push_item
);
	import dmgr_pkg::*;

	logic vld_s1;
	item_t item_s1;
	logic accept;

	assign busy   = kbusy || q_stat.afull;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.s1     <= ammonium_conc;
			item_s1.s2     <= oxygen_conc;
			item_s1.dens   <= biomass_density;
			item_s1.in_dom <= in_domain;
			item_s1.last   <= last_cell;
			item_s1.den1   <= 33'(ammonium_conc) + 33'(cfg.k1);
			item_s1.den2   <= 33'(oxygen_conc) + 33'(cfg.k2);
		end
	end

	assign push      = vld_s1;
	assign push_item = item_s1;

endmodule

// ----- hw/rtl/dmgr_back.sv -----
// Compute pipeline: two Monod fraction dividers, the rate products, the
// oxygen term and the ammonium divider, one cell per cycle. Uses dmgr_pkg.
module dmgr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  dmgr_pkg::cfg_t     cfg,
	input  dmgr_pkg::q_stat_t  q_stat,
	input  dmgr_pkg::item_t    q_head,
	output logic               q_pop,
	output logic               done,
	output logic signed [39:0] ammonium_rate,
	output logic signed [39:0] oxygen_rate,
	output logic signed [39:0] nitrite_rate,
	output logic signed [39:0] specific_growth,
	output logic               last_out
);
	import dmgr_pkg::*;

	localparam int FD_N = 17;
	localparam int AD_N = 40;

	typedef struct packed {
		logic [32:0] r1;
		logic [32:0] r2;
		logic [16:0] q1;
		logic [16:0] q2;
		logic [16:0] n1;
		logic [16:0] n2;
		logic [32:0] den1;
		logic [32:0] den2;
		logic        z1;
		logic        z2;
		logic [31:0] dens;
		logic        in_dom;
		logic        last;
	} fdiv_t;

	typedef struct packed {
		logic [31:0] r;
		logic [39:0] q;
		logic [39:0] n;
		logic        big;
		logic        az;
		logic [39:0] oxy;
		logic [39:0] grow;
		logic        in_dom;
		logic        last;
	} adiv_t;

	function automatic fdiv_t fd_step(fdiv_t x);
		fdiv_t y;
		logic [33:0] rs1, rs2;
		logic ge1, ge2;
		y   = x;
		rs1 = {x.r1, x.n1[16]};
		rs2 = {x.r2, x.n2[16]};
		ge1 = rs1 >= {1'b0, x.den1};
		ge2 = rs2 >= {1'b0, x.den2};
		y.r1 = ge1 ? 33'(rs1 - {1'b0, x.den1}) : rs1[32:0];
		y.r2 = ge2 ? 33'(rs2 - {1'b0, x.den2}) : rs2[32:0];
		y.q1 = {x.q1[15:0], ge1};
		y.q2 = {x.q2[15:0], ge2};
		y.n1 = {x.n1[15:0], 1'b0};
		y.n2 = {x.n2[15:0], 1'b0};
		return y;
	endfunction

	function automatic adiv_t ad_step(adiv_t x, logic [31:0] d);
		adiv_t y;
		logic [32:0] rs;
		logic ge;
		y   = x;
		rs  = {x.r, x.n[39]};
		ge  = rs >= {1'b0, d};
		y.r = ge ? 32'(rs - {1'b0, d}) : rs[31:0];
		y.q = {x.q[38:0], ge};
		y.n = {x.n[38:0], 1'b0};
		return y;
	endfunction

	// Monod fraction dividers
	fdiv_t fd_in;
	fdiv_t fd_s [1:FD_N];
	logic  fd_vld_s [1:FD_N];

	assign q_pop = !q_stat.empty;

	// the top 31 numerator bits never reach the denominator: start past them
	always_comb begin
		fd_in.r1     = {2'd0, q_head.s1[31:1]};
		fd_in.r2     = {2'd0, q_head.s2[31:1]};
		fd_in.q1     = '0;
		fd_in.q2     = '0;
		fd_in.n1     = {q_head.s1[0], 16'd0};
		fd_in.n2     = {q_head.s2[0], 16'd0};
		fd_in.den1   = q_head.den1;
		fd_in.den2   = q_head.den2;
		fd_in.z1     = q_head.den1 == '0;
		fd_in.z2     = q_head.den2 == '0;
		fd_in.dens   = q_head.dens;
		fd_in.in_dom = q_head.in_dom;
		fd_in.last   = q_head.last;
	end

	for (genvar j = 0; j < FD_N; j++) begin : g_fd
		if (j == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) fd_vld_s[1] <= 1'b0;
				else fd_vld_s[1] <= q_pop;
			end
			always_ff @(posedge clk) begin
				fd_s[1] <= fd_step(fd_in);
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) fd_vld_s[j+1] <= 1'b0;
				else fd_vld_s[j+1] <= fd_vld_s[j];
			end
			always_ff @(posedge clk) begin
				fd_s[j+1] <= fd_step(fd_s[j]);
			end
		end
	end

	// rate products
	logic [16:0] f1, f2;
	logic [48:0] p_gf, p_t2;
	assign f1   = fd_s[FD_N].z1 ? '0 : fd_s[FD_N].q1;
	assign f2   = fd_s[FD_N].z2 ? '0 : fd_s[FD_N].q2;
	assign p_gf = 49'(cfg.growth) * 49'(f1);
	assign p_t2 = 49'(cfg.maint) * 49'(f2);

	logic        vld_mul_s1, vld_mul_s2, vld_mul_s3;
	logic [31:0] gf_mul_s1, t2_mul_s1, dens_mul_s1;
	logic [16:0] f2_mul_s1;
	logic        in_mul_s1, last_mul_s1;
	logic [31:0] t1_mul_s2, t2_mul_s2, dens_mul_s2;
	logic        in_mul_s2, last_mul_s2;
	logic [47:0] u_mul_s3, mm_mul_s3;
	logic [34:0] grow_mul_s3;
	logic        in_mul_s3, last_mul_s3;
	logic [48:0] p_t1;
	logic [63:0] p_u, p_m;

	assign p_t1 = 49'(gf_mul_s1) * 49'(f2_mul_s1);
	assign p_u  = 64'(t1_mul_s2) * 64'(dens_mul_s2);
	assign p_m  = 64'(t2_mul_s2) * 64'(dens_mul_s2);

	always_ff @(posedge clk) begin
		gf_mul_s1   <= p_gf[47:16];
		t2_mul_s1   <= p_t2[47:16];
		f2_mul_s1   <= f2;
		dens_mul_s1 <= fd_s[FD_N].dens;
		in_mul_s1   <= fd_s[FD_N].in_dom;
		last_mul_s1 <= fd_s[FD_N].last;

		t1_mul_s2   <= p_t1[47:16];
		t2_mul_s2   <= t2_mul_s1;
		dens_mul_s2 <= dens_mul_s1;
		in_mul_s2   <= in_mul_s1;
		last_mul_s2 <= last_mul_s1;

		u_mul_s3    <= p_u[63:16];
		mm_mul_s3   <= p_m[63:16];
		grow_mul_s3 <= 35'(t1_mul_s2) - 35'(t2_mul_s2) - 35'(cfg.decay);
		in_mul_s3   <= in_mul_s2;
		last_mul_s3 <= last_mul_s2;
	end

	// oxygen term: |Kc|*U in two partial products, clamp, then saturate
	logic        vld_ox_s4, vld_ox_s5, vld_ox_s6;
	logic [58:0] pl_ox_s4, ph_ox_s4;
	logic [47:0] u_ox_s4, mm_ox_s4, u_ox_s5, mm_ox_s5, u_ox_s6;
	logic [34:0] grow_ox_s4, grow_ox_s5, grow_ox_s6;
	logic        in_ox_s4, in_ox_s5, in_ox_s6, last_ox_s4, last_ox_s5, last_ox_s6;
	logic [50:0] omag_ox_s5;
	logic [39:0] oxy_ox_s6;
	logic [82:0] ox_prod;
	logic [50:0] ox_hi;
	logic [52:0] ox_sum;
	logic [39:0] ox_sat;

	assign ox_prod = {ph_ox_s4, 24'd0} + 83'(pl_ox_s4);
	assign ox_hi   = ox_prod[66:16];

	always_comb begin
		if (cfg.kneg) begin
			ox_sum = 53'(omag_ox_s5) - 53'(mm_ox_s5);
		end else begin
			ox_sum = 53'd0 - 53'(omag_ox_s5) - 53'(mm_ox_s5);
		end
		if (!ox_sum[52] && ox_sum[51:39] != '0) begin
			ox_sat = POS_MAX;
		end else if (ox_sum[52] && ox_sum[51:39] != '1) begin
			ox_sat = NEG_MIN;
		end else begin
			ox_sat = ox_sum[39:0];
		end
	end

	// a full product past the signed 64-bit range jumps to the 2^50 cap
	always_ff @(posedge clk) begin
		pl_ox_s4   <= 59'(cfg.kmag) * 59'(u_mul_s3[23:0]);
		ph_ox_s4   <= 59'(cfg.kmag) * 59'(u_mul_s3[47:24]);
		u_ox_s4    <= u_mul_s3;
		mm_ox_s4   <= mm_mul_s3;
		grow_ox_s4 <= grow_mul_s3;
		in_ox_s4   <= in_mul_s3;
		last_ox_s4 <= last_mul_s3;

		omag_ox_s5 <= (ox_prod[82:63] != '0) ? (51'd1 << 50) : ox_hi;
		u_ox_s5    <= u_ox_s4;
		mm_ox_s5   <= mm_ox_s4;
		grow_ox_s5 <= grow_ox_s4;
		in_ox_s5   <= in_ox_s4;
		last_ox_s5 <= last_ox_s4;

		oxy_ox_s6  <= ox_sat;
		u_ox_s6    <= u_ox_s5;
		grow_ox_s6 <= grow_ox_s5;
		in_ox_s6   <= in_ox_s5;
		last_ox_s6 <= last_ox_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_mul_s1 <= 1'b0;
			vld_mul_s2 <= 1'b0;
			vld_mul_s3 <= 1'b0;
			vld_ox_s4  <= 1'b0;
			vld_ox_s5  <= 1'b0;
			vld_ox_s6  <= 1'b0;
		end else begin
			vld_mul_s1 <= fd_vld_s[FD_N];
			vld_mul_s2 <= vld_mul_s1;
			vld_mul_s3 <= vld_mul_s2;
			vld_ox_s4  <= vld_mul_s3;
			vld_ox_s5  <= vld_ox_s4;
			vld_ox_s6  <= vld_ox_s5;
		end
	end

	// ammonium divider (U<<16)/yield; a quotient at or above 2^40 is flagged
	adiv_t ad_in;
	adiv_t ad_s [1:AD_N];
	logic  ad_vld_s [1:AD_N];

	always_comb begin
		ad_in.r      = {8'd0, u_ox_s6[47:24]};
		ad_in.q      = '0;
		ad_in.n      = {u_ox_s6[23:0], 16'd0};
		ad_in.az     = cfg.yield == '0;
		ad_in.big    = {8'd0, u_ox_s6[47:24]} >= cfg.yield;
		ad_in.oxy    = oxy_ox_s6;
		ad_in.grow   = {{5{grow_ox_s6[34]}}, grow_ox_s6};
		ad_in.in_dom = in_ox_s6;
		ad_in.last   = last_ox_s6;
	end

	for (genvar j = 0; j < AD_N; j++) begin : g_ad
		if (j == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) ad_vld_s[1] <= 1'b0;
				else ad_vld_s[1] <= vld_ox_s6;
			end
			always_ff @(posedge clk) begin
				ad_s[1] <= ad_step(ad_in, cfg.yield);
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) ad_vld_s[j+1] <= 1'b0;
				else ad_vld_s[j+1] <= ad_vld_s[j];
			end
			always_ff @(posedge clk) begin
				ad_s[j+1] <= ad_step(ad_s[j], cfg.yield);
			end
		end
	end

	// saturation and domain mask
	logic [39:0] a_q40, amm_c, nit_c;
	logic        done_q, last_q;
	logic [39:0] amm_q, oxy_q, nit_q, grow_q;
	adiv_t       ad_last;

	assign ad_last = ad_s[AD_N];
	assign a_q40   = ad_last.q;

	always_comb begin
		if (ad_last.az) begin
			amm_c = '0;
			nit_c = '0;
		end else if (ad_last.big) begin
			amm_c = NEG_MIN;
			nit_c = POS_MAX;
		end else begin
			amm_c = (a_q40[39] && a_q40[38:0] != '0) ? NEG_MIN : 40'd0 - a_q40;
			nit_c = a_q40[39] ? POS_MAX : a_q40;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ad_vld_s[AD_N];
		end
	end

	always_ff @(posedge clk) begin
		amm_q  <= ad_last.in_dom ? amm_c : '0;
		oxy_q  <= ad_last.in_dom ? ad_last.oxy : '0;
		nit_q  <= ad_last.in_dom ? nit_c : '0;
		grow_q <= ad_last.grow;
		last_q <= ad_last.last;
	end

	assign done            = done_q;
	assign ammonium_rate   = amm_q;
	assign oxygen_rate     = oxy_q;
	assign nitrite_rate    = nit_q;
	assign specific_growth = grow_q;
	assign last_out        = last_q;

endmodule

// ----- bench/dual_monod_growth_rate_core_tb.sv -----
// Testbench for dual_monod_growth_rate_core: APB register setup, cell stream, result checks.
// Depends on dmgr_pkg and the core RTL only; predicts every result with its own Q16.16 math.
module dual_monod_growth_rate_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dmgr_pkg::*;

	localparam longint CAP_O    = 64'sd1 << 50;
	localparam longint SAT_HI   = 64'sd549755813887;
	localparam longint SAT_LO   = -64'sd549755813888;
	localparam int     DRAIN    = 80;
	localparam int     LIMIT    = 600000;

	typedef struct packed {
		logic [31:0] s1;
		logic [31:0] s2;
		logic [31:0] dens;
		logic        in_dom;
		logic        last;
	} cell_t;

	typedef struct packed {
		logic [39:0] amm;
		logic [39:0] oxy;
		logic [39:0] nit;
		logic [39:0] grow;
		logic        last;
	} rates_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic [31:0] ammonium_conc = '0, oxygen_conc = '0, biomass_density = '0;
	logic in_domain = 1'b0, last_cell = 1'b0;
	logic done;
	logic signed [39:0] ammonium_rate, oxygen_rate, nitrite_rate, specific_growth;
	logic last_out;

	// shadow copy of the register file
	logic [31:0] growth_r = 32'd0, yield_r = YIELD_RST, maint_r = 32'd0;
	logic [31:0] decay_r = 32'd0, k1_r = 32'd0, k2_r = 32'd0;

	rates_t expected_rates[$];
	int     mismatches = 0;
	int     cycles = 0;
	int     gap_pct = 0;

	dual_monod_growth_rate_core dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic longint sat40(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	function automatic longint unsigned monod_frac(longint unsigned s, longint unsigned k);
		longint unsigned den;
		den = s + k;
		if (den == 0) return 0;
		return (s << 16) / den;
	endfunction

	function automatic rates_t predict_rates(cell_t c);
		longint unsigned f1, f2, t1, t2, u, m, a, kmag, p, y;
		longint omag, oterm, oxy, amm, nit, grow;
		bit kneg;
		rates_t r;
		y = yield_r;
		f1 = monod_frac(c.s1, k1_r);
		f2 = monod_frac(c.s2, k2_r);
		t1 = (((64'(growth_r) * f1) >> 16) * f2) >> 16;
		t2 = (64'(maint_r) * f2) >> 16;
		u = (t1 * c.dens) >> 16;
		m = (t2 * c.dens) >> 16;
		a = 0;
		kmag = 0;
		kneg = 1'b0;
		if (y != 0) begin
			a = (u << 16) / y;
			if (y <= STOICH_Q16) kmag = ((64'(STOICH_Q16) - y) << 16) / y;
			else begin
				kmag = ((y - 64'(STOICH_Q16)) << 16) / y;
				kneg = 1'b1;
			end
		end
		if (u != 0 && kmag > 64'h7fff_ffff_ffff_ffff / u) omag = CAP_O;
		else begin
			p = (kmag * u) >> 16;
			omag = (p > CAP_O) ? CAP_O : longint'(p);
		end
		oterm = kneg ? -omag : omag;
		oxy = -(oterm + longint'(m));
		amm = (a > 64'(SAT_HI) + 1) ? SAT_LO : -longint'(a);
		nit = (a > 64'(SAT_HI)) ? SAT_HI : longint'(a);
		grow = longint'(t1) - longint'(t2) - longint'(64'(decay_r));
		r.amm  = c.in_dom ? 40'(sat40(amm)) : '0;
		r.oxy  = c.in_dom ? 40'(sat40(oxy)) : '0;
		r.nit  = c.in_dom ? 40'(sat40(nit)) : '0;
		r.grow = 40'(sat40(grow));
		r.last = c.last;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
		mismatches++;
		$display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
	endtask

	// result checker: every done strobe is one transfer
	always @(posedge clk) begin
		rates_t w;
		if (arst_n && done) begin
			if (expected_rates.size() == 0)
				report_mismatch("unexpected result", ammonium_rate, '0);
			else begin
				w = expected_rates.pop_front();
				if (ammonium_rate !== w.amm) report_mismatch("ammonium_rate", ammonium_rate, w.amm);
				if (oxygen_rate !== w.oxy) report_mismatch("oxygen_rate", oxygen_rate, w.oxy);
				if (nitrite_rate !== w.nit) report_mismatch("nitrite_rate", nitrite_rate, w.nit);
				if (specific_growth !== w.grow)
					report_mismatch("specific_growth", specific_growth, w.grow);
				if (last_out !== w.last) report_mismatch("last_out", 40'(last_out), 40'(w.last));
			end
		end
	end

	task automatic send_cell(cell_t c);
		ammonium_conc <= c.s1;
		oxygen_conc <= c.s2;
		biomass_density <= c.dens;
		in_domain <= c.in_dom;
		last_cell <= c.last;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		expected_rates.push_back(predict_rates(c));
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic settle;
		start <= 1'b0;
		@(posedge clk);
		while (expected_rates.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_GROWTH: growth_r = v;
			REG_YIELD:  yield_r = v;
			REG_MAINT:  maint_r = v;
			REG_DECAY:  decay_r = v;
			REG_K1:     k1_r = v;
			REG_K2:     k2_r = v;
			default: ;
		endcase
	endtask

	task automatic write_all(logic [31:0] g, logic [31:0] y, logic [31:0] mt,
			logic [31:0] dc, logic [31:0] ka, logic [31:0] kb);
		settle();
		write_reg(REG_GROWTH, g);
		write_reg(REG_YIELD, y);
		write_reg(REG_MAINT, mt);
		write_reg(REG_DECAY, dc);
		write_reg(REG_K1, ka);
		write_reg(REG_K2, kb);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			2: return $urandom_range(32'h2_0000);
			3: return 32'd1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	function automatic cell_t rand_cell();
		cell_t c;
		c.s1 = rand_word();
		c.s2 = rand_word();
		c.dens = rand_word();
		c.in_dom = ($urandom_range(9) != 0);
		c.last = ($urandom_range(15) == 0);
		return c;
	endfunction

	task automatic test_reset_values;
		cell_t c;
		c = '{s1: 32'h1_0000, s2: 32'h1_0000, dens: 32'h1_0000, in_dom: 1'b1, last: 1'b1};
		send_cell(c);
		c = '{s1: 32'd0, s2: 32'd0, dens: 32'hffff_ffff, in_dom: 1'b1, last: 1'b0};
		send_cell(c);  // zero denominator with K at reset
	endtask

	task automatic test_directed;
		cell_t c;
		logic [31:0] ext[4] = '{32'd0, 32'd1, 32'h1_0000, 32'hffff_ffff};
		write_all(32'hffff_ffff, 32'd1, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0);
		foreach (ext[i]) begin
			c = '{s1: ext[i], s2: ext[3 - i], dens: ext[i], in_dom: 1'b1, last: i[0]};
			send_cell(c);
		end
		c = '{s1: '1, s2: '1, dens: '1, in_dom: 1'b0, last: 1'b1};
		send_cell(c);
		// yield above 3.42 flips the oxygen stoichiometry sign
		write_all(32'h2_0000, 32'h8_0000, 32'h1000, 32'h1_0000, 32'h8000, 32'hffff_ffff);
		foreach (ext[i]) begin
			c = '{s1: ext[3 - i], s2: ext[i], dens: 32'hffff_ffff, in_dom: 1'b1, last: 1'b0};
			send_cell(c);
		end
		write_all(32'h1_0000, 32'hffff_ffff, 32'd0, 32'd0, 32'hffff_ffff, 32'd1);
		foreach (ext[i]) begin
			c = '{s1: ext[i], s2: ext[i], dens: ext[i], in_dom: 1'b1, last: 1'b1};
			send_cell(c);
		end
		// write to an unmapped index must be ignored
		settle();
		write_reg(7, 32'hdead_beef);
		write_reg(6, 32'h1234_5678);
		c = '{s1: 32'h3_0000, s2: 32'h2_0000, dens: 32'h5_0000, in_dom: 1'b1, last: 1'b0};
		send_cell(c);
		settle();
	endtask

	task automatic test_random_phase(int pct, int n);
		gap_pct = pct;
		for (int i = 0; i < n; i++) begin
			if (i % 170 == 0)
				write_all(rand_word(), ($urandom_range(3) == 0) ? rand_word() | 32'd1 :
					$urandom_range(32'h1000, 32'h8_0000), rand_word(), rand_word(),
					rand_word(), rand_word());
			send_cell(rand_cell());
		end
		settle();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_random_phase(31, 700);
		test_random_phase(58, 650);
		test_random_phase(0, 650);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/dmgr_pkg.sv
hw/rtl/dmgr_cfg.sv
hw/rtl/dmgr_queue.sv
hw/rtl/dmgr_front.sv
hw/rtl/dmgr_back.sv
hw/rtl/dual_monod_growth_rate_core.sv
bench/dual_monod_growth_rate_core_tb.sv
